>>> hdl/tpdl_pkg.sv
`timescale 1ns / 1ps

package tpdl_pkg;

	// voltage limits in 1/256 V
	localparam logic signed [15:0] VOLT_MIN = -16'sd3072;
	localparam logic signed [15:0] VOLT_MAX = 16'sd25600;

	// 1.725 * 0.76142 in Q16, and the rounding offset of the final >> 38
	localparam logic signed [17:0] GAIN_K = 18'sd86078;
	localparam logic [63:0] ROUND_HALF = 64'd137438953472;

	// floor(y / 7) as (y * 9363) >> 16, exact for y below 13107
	localparam logic [13:0] RECIP_7 = 14'd9363;
	localparam logic [16:0] DUTY_OFFSET = 17'd3072;
	localparam logic [15:0] DUTY_HALF = 16'd56;

	localparam int PADDR_W = 5;

	// register indexes
	localparam logic [2:0] REG_FIRST_COS = 3'd0;
	localparam logic [2:0] REG_FIRST_SIN = 3'd1;
	localparam logic [2:0] REG_SECOND_COS = 3'd2;
	localparam logic [2:0] REG_SECOND_SIN = 3'd3;
	localparam logic [2:0] REG_LOOP_GAIN = 3'd4;

	// action codes
	localparam logic [1:0] ACT_REL = 2'd0;
	localparam logic [1:0] ACT_ABS = 2'd1;
	localparam logic [1:0] ACT_SCI = 2'd2;

	// axis order
	localparam logic [1:0] AXIS_FIRST_X = 2'd0;
	localparam logic [1:0] AXIS_FIRST_Y = 2'd1;
	localparam logic [1:0] AXIS_SECOND_X = 2'd2;
	localparam logic [1:0] AXIS_SECOND_Y = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] first_dx;
		logic signed [15:0] first_dy;
		logic signed [15:0] second_dx;
		logic signed [15:0] second_dy;
		logic [1:0]         axis_select;
		logic signed [15:0] target_volts;
	} req_t;

	typedef struct packed {
		logic [7:0] duty_first_x;
		logic [7:0] duty_first_y;
		logic [7:0] duty_second_x;
		logic [7:0] duty_second_y;
		logic [7:0] duty_science;
		logic       range_error;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] first_cos;
		logic signed [15:0] first_sin;
		logic signed [15:0] second_cos;
		logic signed [15:0] second_sin;
		logic [15:0]        loop_gain;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SET,
		OP_TERM_A,
		OP_TERM_B,
		OP_GAIN,
		OP_LO,
		OP_HI,
		OP_UPDATE,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic relative;
	} status_t;

	// round((v - vmin) / 112), saturated at 255
	function automatic logic [7:0] duty_of(logic signed [15:0] v);
		logic signed [16:0] u;
		logic [15:0] x;
		logic [11:0] y;
		logic [25:0] prod;
		logic [9:0] d;
		u = 17'(v) + $signed(DUTY_OFFSET);
		x = u[15:0] + DUTY_HALF;
		y = x[15:4];
		prod = 26'(y) * 26'(RECIP_7);
		d = prod[25:16];
		if (u[16]) begin
			return 8'd0;
		end
		if (d > 10'd255) begin
			return 8'd255;
		end
		return d[7:0];
	endfunction

endpackage

>>> hdl/tiptilt_piezo_drive_loop.sv
`timescale 1ns / 1ps

// drive loop for four tip/tilt piezo axes and one science stack; voltages are
// held in 1/256 V between -12 V and 100 V and reset to -12 V. every item on
// req returns one item on rsp with five pwm duties and a range error flag.
// a relative item rotates both heads' centroid offsets, scales them by the
// loop gain and adds them to the four axes with clamping; one 34x18
// multiplier is stepped five times per axis over four axes, with an update
// step per axis and a set step up front. absolute, science and unused items
// take only the set step before their result. the next item is taken the
// cycle after a result is produced. one item is in work at a time; a
// finished result sits in the output register, so the next item can be taken
// while rsp is stalled, but its own result waits for that register to drain.
// registers on the apb port must be written only while the block is idle; the
// block itself does not enforce this.
module tiptilt_piezo_drive_loop (
	input  logic                          clk,
	input  logic                          arst_n,
	// item in
	input  logic                          req_valid,
	output logic                          req_stall,
	input  tpdl_pkg::req_t                req,
	// item out
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output tpdl_pkg::rsp_t                rsp,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpdl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tpdl_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	status_t status;

	// zero wait state register access
	assign pready = 1'b1;

	// rotation terms and gain register file
	tpdl_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// sequencer: handshakes and the per-axis multiply steps
	tpdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// voltage state, shared multiplier and duty conversion
	tpdl_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.cfg   (cfg),
		.status(status),
		.rsp   (rsp)
	);

endmodule

>>> hdl/tpdl_regs.sv
`timescale 1ns / 1ps

module tpdl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpdl_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output tpdl_pkg::cfg_t                cfg
);
	import tpdl_pkg::*;

	cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_cos <= 16'sd16384;
			cfg_q.first_sin <= 16'sd0;
			cfg_q.second_cos <= 16'sd16384;
			cfg_q.second_sin <= 16'sd0;
			cfg_q.loop_gain <= 16'd256;
		end else if (wr_en) begin
			unique case (idx)
				REG_FIRST_COS: cfg_q.first_cos <= pwdata[15:0];
				REG_FIRST_SIN: cfg_q.first_sin <= pwdata[15:0];
				REG_SECOND_COS: cfg_q.second_cos <= pwdata[15:0];
				REG_SECOND_SIN: cfg_q.second_sin <= pwdata[15:0];
				REG_LOOP_GAIN: cfg_q.loop_gain <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FIRST_COS: prdata = {16'd0, cfg_q.first_cos};
			REG_FIRST_SIN: prdata = {16'd0, cfg_q.first_sin};
			REG_SECOND_COS: prdata = {16'd0, cfg_q.second_cos};
			REG_SECOND_SIN: prdata = {16'd0, cfg_q.second_sin};
			REG_LOOP_GAIN: prdata = {16'd0, cfg_q.loop_gain};
			default: prdata = 32'd0;
		endcase
	end

endmodule

>>> hdl/tpdl_ctrl.sv
`timescale 1ns / 1ps

module tpdl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  tpdl_pkg::status_t status,
	output tpdl_pkg::cmd_t    cmd
);
	import tpdl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SET,
		S_TERM_A,
		S_TERM_B,
		S_GAIN,
		S_LO,
		S_HI,
		S_UPDATE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic [1:0] axis_q;
	logic rsp_valid_q;
	logic out_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		cmd.axis = axis_q;
		unique case (state_q)
			S_IDLE: cmd.op = req_valid ? OP_LOAD : OP_IDLE;
			S_SET: cmd.op = OP_SET;
			S_TERM_A: cmd.op = OP_TERM_A;
			S_TERM_B: cmd.op = OP_TERM_B;
			S_GAIN: cmd.op = OP_GAIN;
			S_LO: cmd.op = OP_LO;
			S_HI: cmd.op = OP_HI;
			S_UPDATE: cmd.op = OP_UPDATE;
			S_FINISH: cmd.op = out_free ? OP_EMIT : OP_IDLE;
			default: cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= AXIS_FIRST_X;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SET;
					end
				end
				S_SET: begin
					axis_q <= AXIS_FIRST_X;
					state_q <= status.relative ? S_TERM_A : S_FINISH;
				end
				S_TERM_A: state_q <= S_TERM_B;
				S_TERM_B: state_q <= S_GAIN;
				S_GAIN: state_q <= S_LO;
				S_LO: state_q <= S_HI;
				S_HI: state_q <= S_UPDATE;
				S_UPDATE: begin
					if (axis_q == AXIS_SECOND_Y) begin
						state_q <= S_FINISH;
					end else begin
						axis_q <= axis_q + 2'd1;
						state_q <= S_TERM_A;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/tpdl_dp.sv
`timescale 1ns / 1ps

module tpdl_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tpdl_pkg::cmd_t    cmd,
	input  tpdl_pkg::req_t    req,
	input  tpdl_pkg::cfg_t    cfg,
	output tpdl_pkg::status_t status,
	output tpdl_pkg::rsp_t    rsp
);
	import tpdl_pkg::*;

	req_t item_q;
	rsp_t rsp_q;
	logic signed [15:0] volts_q [4];
	logic signed [15:0] sci_q;
	logic err_q;

	logic signed [33:0] acc_q;
	logic neg_q;
	logic [47:0] m_q;
	logic [63:0] p_q;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [51:0] prod;
	logic neg_a;
	logic add_b;
	logic [33:0] abs_r;
	logic tgt_ok;
	logic [63:0] rnd;
	logic [25:0] q;
	logic signed [26:0] step;
	logic signed [27:0] sum;
	logic signed [15:0] upd;

	assign status.relative = (item_q.action == ACT_REL);
	assign rsp = rsp_q;

	assign abs_r = acc_q[33] ? -acc_q : acc_q;
	assign tgt_ok = (item_q.target_volts >= VOLT_MIN) && (item_q.target_volts < VOLT_MAX);

	// multiplier operands: per-axis rotation terms, loop gain and constant gain
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		neg_a = 1'b0;
		add_b = 1'b0;
		unique case (cmd.op)
			OP_TERM_A: begin
				unique case (cmd.axis)
					AXIS_FIRST_X: begin
						mul_a = 34'(cfg.first_cos);
						mul_b = 18'(item_q.first_dx);
					end
					AXIS_FIRST_Y: begin
						mul_a = 34'(cfg.first_sin);
						mul_b = 18'(item_q.first_dx);
						neg_a = 1'b1;
					end
					AXIS_SECOND_X: begin
						mul_a = 34'(cfg.second_cos);
						mul_b = 18'(item_q.second_dx);
					end
					default: begin
						mul_a = 34'(cfg.second_sin);
						mul_b = 18'(item_q.second_dx);
					end
				endcase
			end
			OP_TERM_B: begin
				unique case (cmd.axis)
					AXIS_FIRST_X: begin
						mul_a = 34'(cfg.first_sin);
						mul_b = 18'(item_q.first_dy);
					end
					AXIS_FIRST_Y: begin
						mul_a = 34'(cfg.first_cos);
						mul_b = 18'(item_q.first_dy);
					end
					AXIS_SECOND_X: begin
						mul_a = 34'(cfg.second_sin);
						mul_b = 18'(item_q.second_dy);
					end
					default: begin
						mul_a = 34'(cfg.second_cos);
						mul_b = 18'(item_q.second_dy);
						add_b = 1'b1;
					end
				endcase
			end
			OP_GAIN: begin
				mul_a = $signed({2'b00, abs_r[31:0]});
				mul_b = $signed({2'b00, cfg.loop_gain});
			end
			OP_LO: begin
				mul_a = $signed({10'd0, m_q[23:0]});
				mul_b = GAIN_K;
			end
			OP_HI: begin
				mul_a = $signed({10'd0, m_q[47:24]});
				mul_b = GAIN_K;
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// round half away from zero on the magnitude, then clamp
	assign rnd = p_q + ROUND_HALF;
	assign q = rnd[63:38];
	assign step = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign sum = 28'(volts_q[cmd.axis]) + 28'(step);

	always_comb begin
		if (sum > 28'(VOLT_MAX)) begin
			upd = VOLT_MAX;
		end else if (sum < 28'(VOLT_MIN)) begin
			upd = VOLT_MIN;
		end else begin
			upd = sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: item_q <= req;
			OP_TERM_A: acc_q <= neg_a ? -prod[33:0] : prod[33:0];
			OP_TERM_B: acc_q <= add_b ? acc_q + prod[33:0] : acc_q - prod[33:0];
			OP_GAIN: begin
				m_q <= prod[47:0];
				neg_q <= acc_q[33];
			end
			OP_LO: p_q <= {23'd0, prod[40:0]};
			OP_HI: p_q <= p_q + {prod[39:0], 24'd0};
			OP_EMIT: begin
				rsp_q.duty_first_x <= duty_of(volts_q[AXIS_FIRST_X]);
				rsp_q.duty_first_y <= duty_of(volts_q[AXIS_FIRST_Y]);
				rsp_q.duty_second_x <= duty_of(volts_q[AXIS_SECOND_X]);
				rsp_q.duty_second_y <= duty_of(volts_q[AXIS_SECOND_Y]);
				rsp_q.duty_science <= duty_of(sci_q);
				rsp_q.range_error <= err_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				volts_q[i] <= VOLT_MIN;
			end
			sci_q <= VOLT_MIN;
			err_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_SET: begin
					err_q <= 1'b0;
					if (item_q.action == ACT_ABS || item_q.action == ACT_SCI) begin
						if (!tgt_ok) begin
							err_q <= 1'b1;
						end else if (item_q.action == ACT_ABS) begin
							volts_q[item_q.axis_select] <= item_q.target_volts;
						end else begin
							sci_q <= item_q.target_volts;
						end
					end
				end
				OP_UPDATE: volts_q[cmd.axis] <= upd;
				default: ;
			endcase
		end
	end

endmodule
